// ----- hdl/vdi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_pkg: shared types, constants and functions of the vertex indexer.
// Sizes of the slot memory, the index space and the hash helpers.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int MaxVertices = 4096;
  localparam int TableSlots  = 8192;
  localparam int SlotW       = $clog2(TableSlots);
  localparam int CountW      = $clog2(MaxVertices) + 1;
  localparam int IndexW      = 12;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec3_t;

  typedef struct packed {
    logic [CountW-1:0] index;
    vec3_t             key;
  } slot_data_t;

  typedef struct packed {
    logic              start;
    logic [SlotW-1:0]  slot;
  } hash_res_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:0] > 31'h7F800000);
  endfunction

  function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b)) begin
      r = 1'b0;
    end else if ((a[30:0] | b[30:0]) == 31'd0) begin
      r = 1'b1;
    end else begin
      r = (a == b);
    end
    return r;
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] b);
    return (b == 32'h80000000) ? 32'd0 : b;
  endfunction

endpackage

// ----- hdl/vertex_dedup_indexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer: hashed position table that assigns vertex indices.
// Linear probing over a one-port slot memory; a clear bumps an epoch.
// ----------------------------------------------------------------------------
// Channel  Dir  Sideband                   Data
// s_axis   in   tuser op                   tdata pos x,y,z, normal x,y,z
// m_axis   out  tuser is_new, table_full   tdata index, pos x,y,z, normal x,y,z
// A lookup runs the hash, then each probe passes through S_READ and S_CHECK;
// the result is registered in S_CHECK, and the next item is accepted once
// the state is back in S_IDLE. A clear is done in S_IDLE itself. Reset and
// every 255th clear start a sweep over the epoch marks of all 8192 slots,
// with s_axis_tready low. A result waiting in the output register stalls
// only the probe check of the next lookup.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer
  import vdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata,  // vertex_index, pos x,y,z, normal x,y,z, pad 4
  output logic [1:0]   m_axis_tuser   // is_new, table_full
);

  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_HASH, S_READ, S_CHECK} state_t;

  state_t           state;
  vec3_t            pos;
  vec3_t            nrm;
  vec3_t            in_pos;
  vec3_t            in_nrm;
  logic [CountW-1:0] count;
  logic [7:0]       epoch;
  logic [SlotW-1:0] slot;
  logic [SlotW:0]   probes;
  logic             hstart;
  hash_res_t        hres;
  logic             rd_en;
  logic             wr_en;
  logic [SlotW-1:0] addr;
  slot_data_t       wr_data;
  logic [7:0]       wr_epoch;
  slot_data_t       rd_data;
  logic [7:0]       rd_epoch;
  logic             hit_valid;
  logic             match;
  logic             accept;
  logic             out_free;
  logic             res_done;
  logic [195:0]     echo;

  assign in_pos = '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32], z: s_axis_tdata[95:64]};
  assign in_nrm = '{x: s_axis_tdata[127:96], y: s_axis_tdata[159:128],
                    z: s_axis_tdata[191:160]};

  vdi_hash u_hash (.clk, .rst, .start(hstart), .pos(in_pos), .res(hres));

  vdi_table u_table (
    .clk, .rd_en, .wr_en, .addr, .wr_data, .wr_epoch, .rd_data, .rd_epoch
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hit_valid     = (rd_epoch == epoch) && (epoch != 8'd0);
  assign match = feq(rd_data.key.x, pos.x) && feq(rd_data.key.y, pos.y)
              && feq(rd_data.key.z, pos.z);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign res_done = (state == S_CHECK) && out_free
                 && (!hit_valid || match || (probes == (SlotW+1)'(TableSlots - 1)));
  assign echo = {4'd0, nrm.z, nrm.y, nrm.x, pos.z, pos.y, pos.x};

  always_comb begin
    rd_en    = (state == S_READ);
    wr_en    = (state == S_SWEEP)
            || ((state == S_CHECK) && out_free && !hit_valid
                && (count < CountW'(MaxVertices)));
    addr     = slot;
    wr_data  = '{index: count, key: pos};
    wr_epoch = (state == S_SWEEP) ? 8'd0 : epoch;
    hstart   = accept && (s_axis_tuser == OP_LOOKUP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      slot          <= '0;
      count         <= '0;
      epoch         <= 8'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_done) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          slot <= slot + 1'b1;
          if (slot == SlotW'(TableSlots - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pos <= in_pos;
            nrm <= in_nrm;
            if (s_axis_tuser == OP_CLEAR) begin
              count <= '0;
              if (epoch == 8'd255) begin
                epoch <= 8'd1;
                slot  <= '0;
                state <= S_SWEEP;
              end else begin
                epoch <= epoch + 8'd1;
              end
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          probes <= '0;
          if (hres.start) begin
            slot  <= hres.slot;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        default: begin
          if (out_free) begin
            if (!hit_valid) begin
              state <= S_IDLE;
              if (count < CountW'(MaxVertices)) begin
                count        <= count + 1'b1;
                m_axis_tuser <= 2'b01;
                m_axis_tdata <= {echo, count[IndexW-1:0]};
              end else begin
                m_axis_tuser <= 2'b10;
                m_axis_tdata <= {echo, {IndexW{1'b0}}};
              end
            end else if (match) begin
              state        <= S_IDLE;
              m_axis_tuser <= 2'b00;
              m_axis_tdata <= {echo, rd_data.index[IndexW-1:0]};
            end else if (probes == (SlotW+1)'(TableSlots - 1)) begin
              state        <= S_IDLE;
              m_axis_tuser <= 2'b10;
              m_axis_tdata <= {echo, {IndexW{1'b0}}};
            end else begin
              probes <= probes + 1'b1;
              slot   <= slot + 1'b1;
              state  <= S_READ;
            end
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output item changed while waiting");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("new and full both set");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxVertices))
    else $error("count over limit");
`endif

endmodule

// ----- hdl/vdi_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_hash: multi-cycle position hash.
// Runs three mix rounds, each two multiplies over registered steps.
// ----------------------------------------------------------------------------
module vdi_hash
  import vdi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  vec3_t     pos,
  output hash_res_t res
);

  logic [3:0]       step;
  logic [1:0]       round;
  logic [31:0]      h;
  logic [31:0]      mul_in;
  logic [31:0]      mul_k;
  logic [31:0]      prod;
  logic             busy;
  logic             done;
  logic [SlotW-1:0] slot_r;
  vec3_t            key;

  always_comb begin
    mul_k = (step == 4'd0) ? 32'h7FEB352D : 32'h846CA68B;
  end

  assign prod = mul_in * mul_k;
  assign res  = '{start: done, slot: slot_r};

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (step == 4'd3) && (round == 2'd2);
    if (rst) begin
      busy  <= 1'b0;
      step  <= '0;
      round <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      round  <= '0;
      step   <= '0;
      key    <= pos;
      mul_in <= canon(pos.x) ^ (canon(pos.x) >> 16);
    end else if (busy) begin
      unique case (step)
        4'd0: begin
          h    <= prod;
          step <= 4'd1;
        end
        4'd1: begin
          mul_in <= h ^ (h >> 15);
          step   <= 4'd2;
        end
        4'd2: begin
          h    <= prod;
          step <= 4'd3;
        end
        default: begin
          if (round == 2'd2) begin
            busy   <= 1'b0;
            slot_r <= SlotW'((h ^ (h >> 16)) % TableSlots);
          end else begin
            round <= round + 2'd1;
            if (round == 2'd0) begin
              mul_in <= (h ^ (h >> 16) ^ canon(key.y) ^ 32'h9E3779B9)
                      ^ ((h ^ (h >> 16) ^ canon(key.y) ^ 32'h9E3779B9) >> 16);
            end else begin
              mul_in <= (h ^ (h >> 16) ^ canon(key.z) ^ 32'h85EBCA6B)
                      ^ ((h ^ (h >> 16) ^ canon(key.z) ^ 32'h85EBCA6B) >> 16);
            end
          end
          step <= 4'd0;
        end
      endcase
    end
  end

endmodule

// ----- hdl/vdi_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_table: slot memory with per-slot epoch marks.
// One read or one write per cycle, read data registered.
// ----------------------------------------------------------------------------
module vdi_table
  import vdi_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [SlotW-1:0] addr,
  input  slot_data_t       wr_data,
  input  logic [7:0]       wr_epoch,
  output slot_data_t       rd_data,
  output logic [7:0]       rd_epoch
);

  slot_data_t mem [TableSlots];
  logic [7:0] emem [TableSlots];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr]  <= wr_data;
      emem[addr] <= wr_epoch;
    end else if (rd_en) begin
      rd_data  <= mem[addr];
      rd_epoch <= emem[addr];
    end
  end

endmodule

// ----- tb/vertex_dedup_indexer_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_check: scoreboard for the vertex indexer.
// Watches both streams, predicts each result with its own hash table, and
// compares every output item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_check
  import vdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [207:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [11:0] vertex_index;
    logic        is_new;
    logic        table_full;
    logic [31:0] px, py, pz, nx, ny, nz;
  } vertex_rec_t;

  bit          used[TableSlots];
  logic [31:0] kx[TableSlots], ky[TableSlots], kz[TableSlots];
  int          kidx[TableSlots];
  int          n_unique;
  vertex_rec_t expected_recs[$];

  function automatic logic is_nan_bits(input logic [31:0] b);
    return (b[30:0] > 31'h7F800000);
  endfunction

  function automatic logic same_coord(input logic [31:0] a, input logic [31:0] b);
    if (is_nan_bits(a) || is_nan_bits(b)) return 1'b0;
    if (((a | b) & 32'h7FFFFFFF) == 0) return 1'b1;
    return a == b;
  endfunction

  function automatic logic [31:0] zero_fold(input logic [31:0] b);
    return (b == 32'h80000000) ? 32'd0 : b;
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] v);
    logic [31:0] h;
    h = v;
    h ^= h >> 16;
    h = h * 32'h7FEB352D;
    h ^= h >> 15;
    h = h * 32'h846CA68B;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic vertex_rec_t index_vertex(input logic [191:0] d);
    vertex_rec_t r;
    logic [31:0] h;
    int s;
    bit found;
    r = '0;
    {r.nz, r.ny, r.nx, r.pz, r.py, r.px} = d;
    h = scramble(zero_fold(r.px));
    h = scramble(h ^ zero_fold(r.py) ^ 32'h9E3779B9);
    h = scramble(h ^ zero_fold(r.pz) ^ 32'h85EBCA6B);
    s = h % TableSlots;
    found = 0;
    for (int n = 0; n < TableSlots && !found; n++) begin
      if (!used[s]) begin
        if (n_unique >= MaxVertices) begin
          r.table_full = 1'b1;
        end else begin
          used[s] = 1;
          kx[s] = r.px;
          ky[s] = r.py;
          kz[s] = r.pz;
          kidx[s] = n_unique;
          r.vertex_index = 12'(n_unique);
          r.is_new = 1'b1;
          n_unique++;
        end
        found = 1;
      end else if (same_coord(kx[s], r.px) && same_coord(ky[s], r.py) &&
                   same_coord(kz[s], r.pz)) begin
        r.vertex_index = 12'(kidx[s]);
        found = 1;
      end else begin
        s = (s + 1) % TableSlots;
      end
    end
    if (!found) r.table_full = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    vertex_rec_t got, want;
    if (rst) begin
      for (int i = 0; i < TableSlots; i++) used[i] = 0;
      n_unique = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_CLEAR) begin
          for (int i = 0; i < TableSlots; i++) used[i] = 0;
          n_unique = 0;
        end else begin
          expected_recs = {expected_recs, index_vertex(s_axis_tdata)};
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.vertex_index = m_axis_tdata[11:0];
        {got.nz, got.ny, got.nx, got.pz, got.py, got.px} = m_axis_tdata[203:12];
        got.is_new = m_axis_tuser[0];
        got.table_full = m_axis_tuser[1];
        if (expected_recs.size() == 0) begin
          report_mismatch("unexpected item", 32'd0, 32'd0);
        end else begin
          want = expected_recs.pop_front();
          if (got.vertex_index != want.vertex_index)
            report_mismatch("vertex_index", 32'(got.vertex_index), 32'(want.vertex_index));
          if (got.is_new != want.is_new)
            report_mismatch("is_new", 32'(got.is_new), 32'(want.is_new));
          if (got.table_full != want.table_full)
            report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
          if (got.px != want.px) report_mismatch("out_pos_x", got.px, want.px);
          if (got.py != want.py) report_mismatch("out_pos_y", got.py, want.py);
          if (got.pz != want.pz) report_mismatch("out_pos_z", got.pz, want.pz);
          if (got.nx != want.nx) report_mismatch("out_normal_x", got.nx, want.nx);
          if (got.ny != want.ny) report_mismatch("out_normal_y", got.ny, want.ny);
          if (got.nz != want.nz) report_mismatch("out_normal_z", got.nz, want.nz);
        end
      end
    end
    pending = expected_recs.size();
  end

endmodule

// ----- tb/vertex_dedup_indexer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_test: stimulus and verdict for the vertex indexer.
// Drives directed and random meshes with repeats, signed zeros, NaNs and
// clears, with random gaps and a long output hold-off.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_test;
  import vdi_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         s_axis_tuser = OP_LOOKUP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [207:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           fail_count, pending;
  longint       cycle_count = 0;
  bit           hold_off = 0;
  logic [95:0]  mesh_pos[$];

  always #5 clk = ~clk;

  vertex_dedup_indexer dut (.*);
  vertex_dedup_indexer_check checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 64'd20_000_000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  task automatic send(input logic op, input logic [95:0] p);
    logic [95:0] nrm;
    int g;
    nrm = {$urandom, $urandom, $urandom};
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {nrm[95:64], nrm[63:32], nrm[31:0], p[95:64], p[63:32], p[31:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h00000000;
      1: return 32'h80000000;
      2: return 32'h7FC00000 | $urandom_range(0, 255);
      3: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vertex();
    logic [95:0] p;
    if (mesh_pos.size() > 0 && $urandom_range(0, 99) < 55) begin
      p = mesh_pos[$urandom_range(0, mesh_pos.size() - 1)];
      if ($urandom_range(0, 9) == 0) p[31] = ~p[31];
    end else begin
      p = ($urandom_range(0, 3) == 0) ? {rand_coord(), rand_coord(), rand_coord()}
                                      : {$urandom, $urandom, $urandom};
      mesh_pos = {mesh_pos, p};
    end
    send(OP_LOOKUP, p);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Directed: extremes, signed zeros, NaNs, repeats, clear.
    send(OP_LOOKUP, 96'h0);
    send(OP_LOOKUP, {32'h80000000, 32'h80000000, 32'h80000000});
    send(OP_LOOKUP, {96{1'b1}});
    send(OP_LOOKUP, {96{1'b1}});
    send(OP_LOOKUP, {32'h7FC00000, 32'h0, 32'h0});
    send(OP_LOOKUP, {32'h7FC00000, 32'h0, 32'h0});
    send(OP_LOOKUP, {32'h7F800000, 32'hFF800000, 32'h3F800000});
    send(OP_LOOKUP, {32'h7F800000, 32'hFF800000, 32'h3F800000});
    send(OP_LOOKUP, {32'h00000000, 32'h80000000, 32'h7F800001});
    send(OP_CLEAR, {$urandom, $urandom, $urandom});
    send(OP_LOOKUP, {96{1'b1}});
    send(OP_LOOKUP, 96'h0);
    // Long output hold-off while the sender keeps offering items.
    fork
      begin
        @(negedge clk);
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      repeat (12) send_vertex();
    join
    send(OP_CLEAR, 96'h0);
    mesh_pos.delete();
    // Random meshes.
    for (int i = 0; i < 1520; i++) begin
      if ($urandom_range(0, 199) == 0) begin
        send(OP_CLEAR, {$urandom, $urandom, $urandom});
        mesh_pos.delete();
      end else begin
        send_vertex();
      end
    end
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
